@@ rtl/crfr_pkg.sv @@
// Shared types and constants for the checksummed record frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package crfr_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [2:0] REC_LAST_POS = 3'd4;

    // Slot write issued by the parser when a record completes.
    typedef struct packed {
        logic        en;
        logic [7:0]  id;
        logic [31:0] word;
    } t_slot_wr;

endpackage

`default_nettype wire

@@ rtl/crfr_if.sv @@
// Handshake channel interfaces for received bytes and slot results.
`timescale 1ns / 1ps
`default_nettype none

interface crfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crfr_slot_if;
    logic        valid;
    logic        ready;
    logic [3:0]  slot_id;
    logic [31:0] slot_word;
    logic        last;

    modport source (output valid, output slot_id, output slot_word, output last, input ready);
    modport sink   (input valid, input slot_id, input slot_word, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/checksummed_record_frame_receiver_core.sv @@
// Top level of the checksummed record frame receiver.
`timescale 1ns / 1ps
`default_nettype none

// Receives a byte stream framed as 0xFF, 0x02, RECORDS five-byte records (id byte, then a
// 32-bit word most significant byte first) and an 8-bit additive checksum byte covering
// everything from 0xFF on. Record words land in a slot memory of RECORDS entries; a slot
// valid flag per entry is cleared at each frame start, so unreceived slots report zero.
// While a frame is being received the block takes one byte per cycle. After a checksum
// byte that matches, the input stalls while the sequencer walks the slot memory: each
// result takes a registered read of the single read port, then a load of the output
// register, and any back-pressure on the output holds the burst of RECORDS items. A
// mismatching checksum produces no items and no stall.

module checksummed_record_frame_receiver_core #(
    parameter int RECORDS = 9
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    crfr_byte_if.sink   i_rx,
    crfr_slot_if.source o_res
);
    import crfr_pkg::*;

    localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;

    t_slot_wr           slot_wr;
    logic [RECORDS-1:0] slot_vld;
    logic               frame_ok;
    logic               emit_busy;
    logic               take;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data;

    assign i_rx.ready = !emit_busy;
    assign take       = i_rx.valid && !emit_busy;

    crfr_parser #(
        .RECORDS (RECORDS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (i_rx.rx_byte),
        .o_wr       (slot_wr),
        .o_slot_vld (slot_vld),
        .o_frame_ok (frame_ok)
    );

    crfr_ram #(
        .WIDTH (32),
        .DEPTH (RECORDS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_wr.en),
        .i_waddr (slot_wr.id[AW-1:0]),
        .i_wdata (slot_wr.word),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    crfr_emit #(
        .RECORDS (RECORDS)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (frame_ok),
        .i_slot_vld (slot_vld),
        .i_rdata    (rd_data),
        .o_re       (rd_en),
        .o_raddr    (rd_addr),
        .o_busy     (emit_busy),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

@@ rtl/crfr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module crfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/crfr_parser.sv @@
// Frame parser: header detection, record assembly, checksum and slot valid bits.
`timescale 1ns / 1ps
`default_nettype none

module crfr_parser #(
    parameter int RECORDS = 9
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_take,
    input  wire logic [7:0]          i_byte,
    output crfr_pkg::t_slot_wr       o_wr,
    output logic [RECORDS-1:0]       o_slot_vld,
    output logic                     o_frame_ok
);
    import crfr_pkg::*;

    localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CW = $clog2(RECORDS + 1);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    logic [1:0]         r_phase,  n_phase;
    logic [2:0]         r_pos,    n_pos;
    logic [CW-1:0]      r_rec,    n_rec;
    logic [7:0]         r_id,     n_id;
    logic [7:0]         r_sum,    n_sum;
    logic [23:0]        r_acc,    n_acc;
    logic [RECORDS-1:0] r_vld;
    logic               id_ok;
    logic               clr_vld;

    assign id_ok = ({1'b0, r_id} < 9'(RECORDS));

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_rec      = r_rec;
        n_id       = r_id;
        n_sum      = r_sum;
        n_acc      = r_acc;
        o_wr       = '0;
        o_frame_ok = 1'b0;
        clr_vld    = 1'b0;
        if (i_take) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte == HDR_BYTE) begin
                        n_sum   = HDR_BYTE;
                        n_phase = PH_START;
                    end
                end
                PH_START: begin
                    if (i_byte == START_BYTE) begin
                        n_sum   = r_sum + i_byte;
                        n_rec   = '0;
                        n_pos   = '0;
                        n_acc   = '0;
                        clr_vld = 1'b1;
                        n_phase = PH_BODY;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_BODY: begin
                    n_sum = r_sum + i_byte;
                    if (r_pos == 3'd0) begin
                        n_id  = i_byte;
                        n_acc = '0;
                        n_pos = 3'd1;
                    end else if (r_pos == REC_LAST_POS) begin
                        o_wr.en   = id_ok;
                        o_wr.id   = r_id;
                        o_wr.word = {r_acc, i_byte};
                        n_pos     = '0;
                        n_rec     = r_rec + 1'b1;
                        if (r_rec == CW'(RECORDS - 1)) begin
                            n_phase = PH_CHECK;
                        end
                    end else begin
                        n_acc = {r_acc[15:0], i_byte};
                        n_pos = r_pos + 3'd1;
                    end
                end
                PH_CHECK: begin
                    o_frame_ok = (i_byte == r_sum);
                    n_phase    = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_rec   <= '0;
            r_id    <= '0;
            r_sum   <= '0;
            r_acc   <= '0;
            r_vld   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_rec   <= n_rec;
            r_id    <= n_id;
            r_sum   <= n_sum;
            r_acc   <= n_acc;
            if (clr_vld) begin
                r_vld <= '0;
            end else if (o_wr.en) begin
                r_vld[o_wr.id[AW-1:0]] <= 1'b1;
            end
        end
    end

    assign o_slot_vld = r_vld;

endmodule

`default_nettype wire

@@ rtl/crfr_emit.sv @@
// Result sequencer: walks the slot memory in order and drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module crfr_emit #(
    parameter int RECORDS = 9
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [RECORDS-1:0]  i_slot_vld,
    input  wire logic [31:0]         i_rdata,
    output logic                     o_re,
    output logic [((RECORDS > 1) ? $clog2(RECORDS) : 1)-1:0] o_raddr,
    output logic                     o_busy,
    crfr_slot_if.source              o_res
);
    import crfr_pkg::*;

    localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;

    localparam logic STEP_READ = 1'b0;
    localparam logic STEP_LOAD = 1'b1;

    logic          r_busy,  n_busy;
    logic          r_step,  n_step;
    logic [AW-1:0] r_k,     n_k;
    logic          r_ovld,  n_ovld;
    logic [3:0]    r_oid,   n_oid;
    logic [31:0]   r_oword, n_oword;
    logic          r_olast, n_olast;
    logic          at_last;

    assign at_last = (r_k == AW'(RECORDS - 1));

    always_comb begin
        n_busy  = r_busy;
        n_step  = r_step;
        n_k     = r_k;
        n_ovld  = r_ovld;
        n_oid   = r_oid;
        n_oword = r_oword;
        n_olast = r_olast;
        o_re    = 1'b0;
        if (r_ovld && o_res.ready) begin
            n_ovld = 1'b0;
        end
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = STEP_READ;
                n_k    = '0;
            end
        end else begin
            unique case (r_step)
                STEP_READ: begin
                    o_re   = 1'b1;
                    n_step = STEP_LOAD;
                end
                STEP_LOAD: begin
                    // Slots never written in this frame read as zero.
                    if (!r_ovld || o_res.ready) begin
                        n_ovld  = 1'b1;
                        n_oid   = 4'(r_k);
                        n_oword = i_slot_vld[r_k] ? i_rdata : 32'd0;
                        n_olast = at_last;
                        if (at_last) begin
                            n_busy = 1'b0;
                        end else begin
                            n_k    = r_k + 1'b1;
                            n_step = STEP_READ;
                        end
                    end
                end
                default: n_step = STEP_READ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_READ;
            r_k    <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_k    <= n_k;
            r_ovld <= n_ovld;
        end
        r_oid   <= n_oid;
        r_oword <= n_oword;
        r_olast <= n_olast;
    end

    assign o_raddr         = r_k;
    assign o_busy          = r_busy;
    assign o_res.valid     = r_ovld;
    assign o_res.slot_id   = r_oid;
    assign o_res.slot_word = r_oword;
    assign o_res.last      = r_olast;

endmodule

`default_nettype wire

@@ dv/tb_checksummed_record_frame_receiver_core.sv @@
// Self-checking testbench for the checksummed record frame receiver core.
`timescale 1ns / 1ps

module tb_checksummed_record_frame_receiver_core;
    import crfr_pkg::*;

    localparam int NUM_SLOTS  = 9;
    localparam int RAND_ITEMS = 55;
    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [1:0] {PH_WAIT_HDR, PH_WAIT_START, PH_BODY, PH_WAIT_SUM} t_parse_phase;
    typedef enum logic [1:0] {ROW_BYTE, ROW_BAD_START, ROW_FRAME} t_row_kind;
    typedef enum logic [1:0] {ID_ASC, ID_HIGH, ID_REPEAT, ID_RAND} t_id_mode;
    typedef enum logic [1:0] {W_ZERO, W_ONES, W_RAND} t_word_mode;
    // Where the expected results of a byte come from: the predictor or the table.
    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_ZERO, EXP_ONES} t_expect_src;

    typedef struct packed {
        logic [3:0]  slot_id;
        logic [31:0] word;
        logic        last;
    } t_slot_result;

    typedef struct {
        logic [7:0]  data;
        t_expect_src src;
        logic        row_end;
    } t_rx_item;

    typedef struct {
        t_row_kind   kind;
        logic [7:0]  data;
        t_id_mode    idm;
        t_word_mode  wm;
        logic        bad_sum;
        t_expect_src src;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crfr_byte_if rx_if();
    crfr_slot_if res_if();

    checksummed_record_frame_receiver_core #(
        .RECORDS(NUM_SLOTS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_res  (res_if)
    );

    always #4 i_clk = ~i_clk;

    // Frame parser state as seen by the predictor.
    t_parse_phase rx_phase = PH_WAIT_HDR;
    logic [2:0]   rec_pos = '0;
    logic [3:0]   rec_count = '0;
    logic [7:0]   rec_id = '0;
    logic [7:0]   rx_sum = '0;
    logic [31:0]  rec_word = '0;
    logic [31:0]  slot_words [NUM_SLOTS] = '{default: '0};

    t_slot_result parsed_q[$];
    t_slot_result slot_expect_q[$];
    t_rx_item     rx_items[$];
    t_row         directed_rows [6];

    int  mismatches = 0;
    int  rand_bytes = 0;
    int  idle_cycles = 0;
    bit  rx_steady = 1'b0;

    task automatic parse_rx_byte(input logic [7:0] b);
        t_slot_result r;
        case (rx_phase)
            PH_WAIT_HDR: begin
                if (b == HDR_BYTE) begin
                    rx_sum = HDR_BYTE;
                    rx_phase = PH_WAIT_START;
                end
            end
            PH_WAIT_START: begin
                // A wrong second byte is swallowed, even a second header byte.
                if (b == START_BYTE) begin
                    rx_sum = rx_sum + b;
                    slot_words = '{default: '0};
                    rec_count = '0;
                    rec_pos = '0;
                    rec_word = '0;
                    rx_phase = PH_BODY;
                end else begin
                    rx_phase = PH_WAIT_HDR;
                end
            end
            PH_BODY: begin
                rx_sum = rx_sum + b;
                if (rec_pos == 0) begin
                    rec_id = b;
                    rec_word = '0;
                    rec_pos = 3'd1;
                end else begin
                    rec_word = {rec_word[23:0], b};
                    if (rec_pos >= REC_LAST_POS) begin
                        // Records with an id past the last slot are counted but dropped.
                        if (rec_id < NUM_SLOTS)
                            slot_words[rec_id[3:0]] = rec_word;
                        rec_pos = '0;
                        rec_count = rec_count + 1'b1;
                        if (rec_count >= NUM_SLOTS)
                            rx_phase = PH_WAIT_SUM;
                    end else begin
                        rec_pos = rec_pos + 1'b1;
                    end
                end
            end
            default: begin
                if (b == rx_sum) begin
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        r.slot_id = 4'(k);
                        r.word = slot_words[k];
                        r.last = (k == NUM_SLOTS - 1);
                        parsed_q.push_back(r);
                    end
                end
                rx_phase = PH_WAIT_HDR;
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic push_item(input logic [7:0] d, input t_expect_src s);
        t_rx_item it;
        it.data = d;
        it.src = s;
        it.row_end = 1'b0;
        rx_items.push_back(it);
    endtask

    task automatic push_expect(input t_slot_result r);
        slot_expect_q.push_back(r);
    endtask

    task automatic queue_frame(input t_id_mode idm, input t_word_mode wm,
                               input logic bad_sum, input t_expect_src s);
        logic [7:0]  sum;
        logic [7:0]  id;
        logic [31:0] w;
        sum = HDR_BYTE + START_BYTE;
        push_item(HDR_BYTE, s);
        push_item(START_BYTE, s);
        for (int k = 0; k < NUM_SLOTS; k++) begin
            case (idm)
                ID_ASC:    id = 8'(k);
                ID_HIGH:   id = (k == 0) ? 8'd9 : (k == 1) ? 8'hFF
                                                           : 8'($urandom_range(9, 255));
                ID_REPEAT: id = 8'(k % 3);
                default:   id = 8'(($urandom_range(0, 3) < 3)
                                   ? $urandom_range(0, NUM_SLOTS - 1)
                                   : $urandom_range(NUM_SLOTS, 255));
            endcase
            case (wm)
                W_ZERO:  w = '0;
                W_ONES:  w = '1;
                default: w = $urandom;
            endcase
            push_item(id, s);
            sum = sum + id;
            for (int j = 3; j >= 0; j--) begin
                push_item(w[j*8 +: 8], s);
                sum = sum + w[j*8 +: 8];
            end
        end
        if (bad_sum)
            sum = sum + 8'($urandom_range(1, 255));
        push_item(sum, s);
    endtask

    task automatic send_item(input t_rx_item it);
        int gap;
        t_slot_result r;
        gap = rx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= it.data;
        do @(posedge i_clk); while (!rx_if.ready);
        parse_rx_byte(it.data);
        if (it.src == EXP_PRED) begin
            while (parsed_q.size() != 0)
                push_expect(parsed_q.pop_front());
        end else begin
            parsed_q.delete();
            if (it.row_end && (it.src == EXP_ZERO || it.src == EXP_ONES)) begin
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    r.slot_id = 4'(k);
                    r.word = (it.src == EXP_ONES) ? '1 : '0;
                    r.last = (k == NUM_SLOTS - 1);
                    push_expect(r);
                end
            end
        end
    endtask

    task automatic send_queued();
        while (rx_items.size() != 0)
            send_item(rx_items.pop_front());
    endtask

    // Sender holds off until every outstanding slot result has been seen.
    task automatic wait_results_drained();
        rx_if.valid <= 1'b0;
        while (slot_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : byte_source
        int seg_pick;
        int seg_count;
        int n;
        logic [7:0] b;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        i_rst_n       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The stray bytes after the first frame keep offering items while its
        // results are held back.
        directed_rows = '{
            '{ROW_FRAME,     8'h00, ID_ASC,    W_ONES, 1'b0, EXP_ONES},
            '{ROW_BYTE,      8'h00, ID_ASC,    W_ZERO, 1'b0, EXP_NONE},
            '{ROW_BYTE,      8'h7E, ID_ASC,    W_ZERO, 1'b0, EXP_NONE},
            '{ROW_BAD_START, 8'h03, ID_ASC,    W_ZERO, 1'b0, EXP_NONE},
            '{ROW_BAD_START, 8'hFF, ID_ASC,    W_ZERO, 1'b0, EXP_NONE},
            '{ROW_BYTE,      8'h02, ID_ASC,    W_ZERO, 1'b0, EXP_NONE}
        };

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_BYTE: begin
                    push_item(directed_rows[i].data, directed_rows[i].src);
                end
                ROW_BAD_START: begin
                    push_item(HDR_BYTE, directed_rows[i].src);
                    push_item(directed_rows[i].data, directed_rows[i].src);
                end
                default: begin
                    queue_frame(directed_rows[i].idm, directed_rows[i].wm,
                                directed_rows[i].bad_sum, directed_rows[i].src);
                end
            endcase
            rx_items[rx_items.size() - 1].row_end = 1'b1;
            send_queued();
        end
        wait_results_drained();

        // Mostly well-formed frames with random content, plus noise and broken frames.
        seg_count = 0;
        while (rand_bytes < RAND_ITEMS) begin
            seg_pick = $urandom_range(0, 99);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (seg_pick < 50) begin
                queue_frame(ID_RAND, W_RAND, 1'b0, EXP_PRED);
            end else if (seg_pick < 65) begin
                queue_frame(ID_RAND, W_RAND, 1'b1, EXP_PRED);
            end else if (seg_pick < 80) begin
                n = $urandom_range(1, 4);
                repeat (n) push_item(8'($urandom_range(0, 255)), EXP_PRED);
            end else if (seg_pick < 90) begin
                b = 8'($urandom_range(0, 255));
                if (b == START_BYTE)
                    b = HDR_BYTE;
                push_item(HDR_BYTE, EXP_PRED);
                push_item(b, EXP_PRED);
            end else begin
                // A cut-off frame; the following bytes finish its body.
                push_item(HDR_BYTE, EXP_PRED);
                push_item(START_BYTE, EXP_PRED);
                n = $urandom_range(1, 40);
                repeat (n) push_item(8'($urandom_range(0, 255)), EXP_PRED);
            end
            rand_bytes += rx_items.size();
            send_queued();
            seg_count++;
            if (seg_count == 4)
                wait_results_drained();
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && slot_expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : result_sink
        t_slot_result got;
        t_slot_result want;
        int hold_left;
        int cyc;
        int seen;
        bit calm;
        bit long_done;
        hold_left = 0;
        cyc = 0;
        seen = 0;
        calm = 1'b0;
        long_done = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.slot_id = res_if.slot_id;
                got.word = res_if.slot_word;
                got.last = res_if.last;
                seen++;
                if (slot_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected slot result: id %0d word %h last %b",
                                 got.slot_id, got.word, got.last);
                end else begin
                    want = slot_expect_q.pop_front();
                    if (got.slot_id !== want.slot_id || got.word !== want.word ||
                        got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("slot result mismatch: expected id %0d word %h last %b",
                                     want.slot_id, want.word, want.last,
                                     ", got id %0d word %h last %b",
                                     got.slot_id, got.word, got.last);
                    end
                end
            end
            cyc++;
            if (cyc % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            // One long back-pressure stretch in the middle of the first burst.
            if (!long_done && seen == 4) begin
                long_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                res_if.ready <= 1'b1;
            end else begin
                hold_left = pick_gap();
                res_if.ready <= (hold_left == 0);
                if (hold_left > 0)
                    hold_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
